### hw/rtl/pea_pkg.sv
// Shared types, codes and constants for the pointer event accumulator.
package pea_pkg;

  // Field widths
  localparam int unsigned TypeW   = 5;
  localparam int unsigned CodeW   = 10;
  localparam int unsigned ValueW  = 16;
  localparam int unsigned PosW    = 16;
  localparam int unsigned BtnW    = 3;
  localparam int unsigned SeqW    = 32;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgW    = 16;

  // Register reset values
  localparam logic [CfgW-1:0] FullScaleRst     = 16'd1000;
  localparam logic [CfgW-1:0] MoveThresholdRst = 16'd1;

  // Item kinds
  localparam logic KindEvent = 1'b0;
  localparam logic KindTick  = 1'b1;

  // Event classes
  localparam logic [TypeW-1:0] TypeSync = 5'd0;
  localparam logic [TypeW-1:0] TypeKey  = 5'd1;
  localparam logic [TypeW-1:0] TypeRel  = 5'd2;

  // Event codes
  localparam logic [CodeW-1:0] CodeAxisX    = 10'd0;
  localparam logic [CodeW-1:0] CodeAxisY    = 10'd1;
  localparam logic [CodeW-1:0] CodeKeyLeft  = 10'd272;
  localparam logic [CodeW-1:0] CodeKeyRight = 10'd273;
  localparam logic [CodeW-1:0] CodeKeyMid   = 10'd274;

  // Button bits
  localparam logic [BtnW-1:0] BitLeft  = 3'b001;
  localparam logic [BtnW-1:0] BitMid   = 3'b010;
  localparam logic [BtnW-1:0] BitRight = 3'b100;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegFullScale     = 8'd0,
    RegMoveThreshold = 8'd1
  } pea_reg_e;

  typedef struct packed {
    logic [CfgW-1:0] full_scale;
    logic [CfgW-1:0] motion_limit;
  } pea_cfg_t;

  typedef struct packed {
    logic                     kind;
    logic [TypeW-1:0]         event_type;
    logic [CodeW-1:0]         event_code;
    logic signed [ValueW-1:0] event_value;
    logic                     link_ready;
  } pea_item_t;

  typedef struct packed {
    logic [PosW-1:0] position_x;
    logic [PosW-1:0] position_y;
    logic [BtnW-1:0] buttons;
    logic [SeqW-1:0] sequence_res;
  } pea_result_t;

endpackage

### hw/rtl/pea_cfg_regs.sv
// Configuration register file: full scale and motion threshold.
module pea_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic [pea_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [pea_pkg::CfgW-1:0]    cfg_data_i,
  output pea_pkg::pea_cfg_t           cfg_o
);
  import pea_pkg::*;

  pea_cfg_t cfg_q, cfg_d;

  // Decode the register index of a write word
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        RegFullScale:     cfg_d.full_scale   = cfg_data_i;
        RegMoveThreshold: cfg_d.motion_limit = cfg_data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.full_scale   <= FullScaleRst;
      cfg_q.motion_limit <= MoveThresholdRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hw/rtl/pea_core.sv
// Event processing: accumulators, positions, buttons and send decision.
module pea_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  pea_pkg::pea_item_t   item_i,
  input  pea_pkg::pea_cfg_t    cfg_i,
  output logic                 emit_o,
  output pea_pkg::pea_result_t result_o
);
  import pea_pkg::*;

  logic signed [ValueW-1:0] dx_q, dx_d, dy_q, dy_d;
  logic                     pending_q, pending_d;
  logic [PosW-1:0]          pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [BtnW-1:0]          btn_q, btn_d, sent_q, sent_d;
  logic                     forced_q, forced_d;
  logic [SeqW-1:0]          seq_q, seq_d;

  logic signed [ValueW-1:0] sat_sum;
  logic signed [ValueW:0]   raw_sum;
  logic signed [ValueW-1:0] acc_sel;
  logic [PosW-1:0]          new_x, new_y;
  logic [ValueW:0]          mag_x, mag_y;
  logic [BtnW-1:0]          key_bit;
  logic                     is_tick, emit;

  // Saturating add of one delta to the selected accumulator
  always_comb begin
    acc_sel = (item_i.event_code == CodeAxisY) ? dy_q : dx_q;
    raw_sum = {acc_sel[ValueW-1], acc_sel} + {item_i.event_value[ValueW-1], item_i.event_value};
    if (raw_sum[ValueW] != raw_sum[ValueW-1]) begin
      sat_sum = raw_sum[ValueW] ? {1'b1, {(ValueW-1){1'b0}}} : {1'b0, {(ValueW-1){1'b1}}};
    end else begin
      sat_sum = raw_sum[ValueW-1:0];
    end
  end

  function automatic logic [PosW-1:0] move_clamp(input logic [PosW-1:0] pos,
                                                 input logic signed [ValueW-1:0] d,
                                                 input logic [CfgW-1:0] fs);
    logic signed [PosW+1:0] p;
    p = $signed({2'b00, pos}) + $signed({{2{d[ValueW-1]}}, d});
    if (p[PosW+1]) begin
      move_clamp = '0;
    end else if (p[PosW:0] > {1'b0, fs}) begin
      move_clamp = fs;
    end else begin
      move_clamp = p[PosW-1:0];
    end
  endfunction

  function automatic logic [ValueW:0] magnitude(input logic signed [ValueW-1:0] v);
    logic [ValueW:0] ext;
    ext = {v[ValueW-1], v};
    magnitude = v[ValueW-1] ? ({(ValueW+1){1'b0}} - ext) : ext;
  endfunction

  assign new_x = move_clamp(pos_x_q, dx_q, cfg_i.full_scale);
  assign new_y = move_clamp(pos_y_q, dy_q, cfg_i.full_scale);
  assign mag_x = magnitude(dx_q);
  assign mag_y = magnitude(dy_q);

  // Map a key code to its button bit
  always_comb begin
    case (item_i.event_code)
      CodeKeyLeft:  key_bit = BitLeft;
      CodeKeyMid:   key_bit = BitMid;
      CodeKeyRight: key_bit = BitRight;
      default:      key_bit = '0;
    endcase
  end

  assign is_tick = (item_i.kind == KindTick);
  assign emit    = fire_i && is_tick && item_i.link_ready &&
                   (forced_q || (btn_q != sent_q));

  // Next state for one item
  always_comb begin
    dx_d      = dx_q;
    dy_d      = dy_q;
    pending_d = pending_q;
    pos_x_d   = pos_x_q;
    pos_y_d   = pos_y_q;
    btn_d     = btn_q;
    sent_d    = sent_q;
    forced_d  = forced_q;
    seq_d     = seq_q;
    if (emit) begin
      sent_d   = btn_q;
      seq_d    = seq_q + SeqW'(1);
      forced_d = 1'b0;
    end else if (fire_i && !is_tick) begin
      case (item_i.event_type)
        TypeRel: begin
          if (item_i.event_code == CodeAxisX) begin
            dx_d      = sat_sum;
            pending_d = 1'b1;
          end else if (item_i.event_code == CodeAxisY) begin
            dy_d      = sat_sum;
            pending_d = 1'b1;
          end
        end
        TypeKey: begin
          if (key_bit != '0) begin
            btn_d    = (item_i.event_value != '0) ? (btn_q | key_bit) : (btn_q & ~key_bit);
            forced_d = 1'b1;
          end
        end
        TypeSync: begin
          if (pending_q) begin
            pos_x_d = new_x;
            pos_y_d = new_y;
            if ((mag_x > {1'b0, cfg_i.motion_limit}) ||
                (mag_y > {1'b0, cfg_i.motion_limit})) begin
              forced_d = 1'b1;
            end
            dx_d      = '0;
            dy_d      = '0;
            pending_d = 1'b0;
          end
        end
        default: begin
          pending_d = pending_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dx_q      <= '0;
      dy_q      <= '0;
      pending_q <= 1'b0;
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      btn_q     <= '0;
      sent_q    <= '0;
      forced_q  <= 1'b0;
      seq_q     <= {{(SeqW-1){1'b0}}, 1'b1};
    end else begin
      dx_q      <= dx_d;
      dy_q      <= dy_d;
      pending_q <= pending_d;
      pos_x_q   <= pos_x_d;
      pos_y_q   <= pos_y_d;
      btn_q     <= btn_d;
      sent_q    <= sent_d;
      forced_q  <= forced_d;
      seq_q     <= seq_d;
    end
  end

  assign emit_o                = emit;
  assign result_o.position_x   = pos_x_q;
  assign result_o.position_y   = pos_y_q;
  assign result_o.buttons      = btn_q;
  assign result_o.sequence_res = seq_q;

endmodule

### hw/rtl/pointer_event_accumulator.sv
// Pointer event accumulator top level: input register, core and result register.
//
// Accepts one word per clock cycle while the held word is not stalled. A word
// is captured in an input register, processed against the accumulator state once
// the result register can take a message, and a tick that sends places its
// message in the result register, which offers it on the output. The single
// result register sets the rate: while it holds an untaken message and
// out_ready_i is low, the held word waits, and so does every input word
// behind it. Configuration writes are taken in every cycle.
module pointer_event_accumulator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input words
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               kind_i,
  input  logic [pea_pkg::TypeW-1:0]          event_type_i,
  input  logic [pea_pkg::CodeW-1:0]          event_code_i,
  input  logic signed [pea_pkg::ValueW-1:0]  event_value_i,
  input  logic                               link_ready_i,
  // Result words
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [pea_pkg::PosW-1:0]           position_x_o,
  output logic [pea_pkg::PosW-1:0]           position_y_o,
  output logic [pea_pkg::BtnW-1:0]           buttons_o,
  output logic [pea_pkg::SeqW-1:0]           sequence_res_o,
  // Configuration writes
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pea_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [pea_pkg::CfgW-1:0]           cfg_data_i
);
  import pea_pkg::*;

  pea_cfg_t    cfg;
  pea_item_t   item_q, item_d;
  logic        item_vld_q;
  logic        fire, emit;
  pea_result_t result, res_q;
  logic        res_vld_q;

  assign cfg_ready_o = 1'b1;

  pea_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Process the held word when the result register can take a message
  assign fire       = item_vld_q && (!res_vld_q || out_ready_i);
  assign in_ready_o = !item_vld_q || fire;

  assign item_d.kind        = kind_i;
  assign item_d.event_type  = event_type_i;
  assign item_d.event_code  = event_code_i;
  assign item_d.event_value = event_value_i;
  assign item_d.link_ready  = link_ready_i;

  // Capture input words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      item_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

  pea_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .emit_o   (emit),
    .result_o (result)
  );

  // Hold a message until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (emit) begin
      res_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= result;
    end
  end

  assign out_valid_o    = res_vld_q;
  assign position_x_o   = res_q.position_x;
  assign position_y_o   = res_q.position_y;
  assign buttons_o      = res_q.buttons;
  assign sequence_res_o = res_q.sequence_res;

endmodule
